// File: sv/rmpc_pkg.sv
package rmpc_pkg;

  // Widths fixed by the item format.
  localparam int RowW    = 6;
  localparam int ColW    = 6;
  localparam int CountW  = 64;
  localparam int InDataW = 16;

  // Default grid edge length.
  localparam int GridSizeDef = 64;

  // Saturation value of every running sum.
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

endpackage

// File: sv/rmpc_ram.sv
module rmpc_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: sv/rmpc_sat_add.sv
module rmpc_sat_add import rmpc_pkg::*; (
  input  logic [CountW-1:0] a_i,
  input  logic [CountW-1:0] b_i,
  output logic [CountW-1:0] sum_o,
  output logic              ovf_o
);

  logic [CountW:0] full_sum;

  // Add with a carry bit and clamp to the largest count on carry out.
  always_comb begin
    full_sum = {1'b0, a_i} + {1'b0, b_i};
    ovf_o    = full_sum[CountW];
    sum_o    = ovf_o ? CountMax : full_sum[CountW-1:0];
  end

endmodule

// File: sv/rook_move_path_count.sv
// The walk visits every cell up to the clamped target row and column, row by row; each
// cell steps through the read, cell, row-add and column-add states, then the finish state
// loads the result once the previous one has been taken. A new item is accepted only when
// idle again; each cell costs one column memory read and three passes through the shared adder.
// Reset: asynchronous active low; clears the sequencer, counters and the output valid.
// The column-sum memory is not reset: row zero writes each entry before it is used.
module rook_move_path_count import rmpc_pkg::*; #(
  parameter int GRID_SIZE = GridSizeDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  // [5:0] row_target, [11:6] col_target, [15:12] zero
  input  logic [InDataW-1:0] s_axis_tdata_i,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  // [63:0] path_count
  output logic [CountW-1:0]  m_axis_tdata_o,
  // [0] saturated
  output logic [0:0]         m_axis_tuser_o
);

  localparam int IdxW = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
  localparam logic [8:0] GridLast = 9'(GRID_SIZE - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CELL,
    ST_ROWADD,
    ST_COLADD,
    ST_FINISH
  } state_e;

  state_e            state_q, state_d;
  logic [IdxW-1:0]   x_q, x_d, y_q, y_d;
  logic [IdxW-1:0]   last_row_q, last_row_d, last_col_q, last_col_d;
  logic [CountW-1:0] row_sum_q, row_sum_d;
  logic [CountW-1:0] cell_q, cell_d;
  logic [CountW-1:0] col_q, col_d;
  logic              ovf_q, ovf_d;
  logic              out_valid_q, out_valid_d;
  logic [CountW-1:0] out_data_q, out_data_d;
  logic              out_user_q, out_user_d;

  logic [8:0]        row_ext, col_ext, row_cl, col_cl;
  logic              in_accept;
  logic [CountW-1:0] add_a, add_b, add_sum;
  logic              add_ovf;
  logic [CountW-1:0] col_rdata, col_in;
  logic              mem_we;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_accept       = s_axis_tvalid_i & s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  // Clamp target indices to the last grid row and column.
  always_comb begin
    row_ext = {3'b000, s_axis_tdata_i[RowW-1:0]};
    col_ext = {3'b000, s_axis_tdata_i[RowW+ColW-1:RowW]};
    row_cl  = (row_ext > GridLast) ? GridLast : row_ext;
    col_cl  = (col_ext > GridLast) ? GridLast : col_ext;
  end

  // Row zero sees cleared column sums, so the memory output is ignored there.
  assign col_in = (x_q == '0) ? '0 : col_rdata;

  // Operand selection for the shared adder.
  always_comb begin
    unique case (state_q)
      ST_CELL: begin
        add_a = row_sum_q;
        add_b = col_in;
      end
      ST_ROWADD: begin
        add_a = row_sum_q;
        add_b = cell_q;
      end
      default: begin
        add_a = col_q;
        add_b = cell_q;
      end
    endcase
  end

  rmpc_sat_add u_add (
    .a_i   (add_a),
    .b_i   (add_b),
    .sum_o (add_sum),
    .ovf_o (add_ovf)
  );

  // Column sums are written back only when a later row still reads them.
  assign mem_we = (state_q == ST_COLADD) && (x_q < last_row_q);

  rmpc_ram #(
    .Width (CountW),
    .Depth (GRID_SIZE)
  ) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (y_q),
    .wdata_i (add_sum),
    .raddr_i (y_q),
    .rdata_o (col_rdata)
  );

  // Sequencer: read, form the cell, update the row sum, update the column sum.
  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    y_d         = y_q;
    last_row_d  = last_row_q;
    last_col_d  = last_col_q;
    row_sum_d   = row_sum_q;
    cell_d      = cell_q;
    col_d       = col_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q & ~m_axis_tready_i;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          last_row_d = row_cl[IdxW-1:0];
          last_col_d = col_cl[IdxW-1:0];
          x_d        = '0;
          y_d        = '0;
          row_sum_d  = '0;
          ovf_d      = 1'b0;
          state_d    = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_CELL;
      end
      ST_CELL: begin
        col_d = col_in;
        if ((x_q == '0) && (y_q == '0)) begin
          cell_d = CountW'(1);
        end else begin
          cell_d = add_sum;
          ovf_d  = ovf_q | add_ovf;
        end
        state_d = ST_ROWADD;
      end
      ST_ROWADD: begin
        if (y_q < last_col_q) begin
          row_sum_d = add_sum;
          ovf_d     = ovf_q | add_ovf;
        end
        state_d = ST_COLADD;
      end
      ST_COLADD: begin
        if (x_q < last_row_q) begin
          ovf_d = ovf_q | add_ovf;
        end
        if (y_q == last_col_q) begin
          if (x_q == last_row_q) begin
            state_d = ST_FINISH;
          end else begin
            x_d       = x_q + 1'b1;
            y_d       = '0;
            row_sum_d = '0;
            state_d   = ST_READ;
          end
        end else begin
          y_d     = y_q + 1'b1;
          state_d = ST_READ;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = cell_q;
          out_user_d  = ovf_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State, counters, running sums and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      x_q         <= '0;
      y_q         <= '0;
      last_row_q  <= '0;
      last_col_q  <= '0;
      row_sum_q   <= '0;
      cell_q      <= '0;
      col_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_user_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      x_q         <= x_d;
      y_q         <= y_d;
      last_row_q  <= last_row_d;
      last_col_q  <= last_col_d;
      row_sum_q   <= row_sum_d;
      cell_q      <= cell_d;
      col_q       <= col_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
      out_user_q  <= out_user_d;
    end
  end

`ifndef ASSERT_OFF
  // An accepted item starts its walk at the origin.
  a_start_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ST_READ) && (x_q == '0) && (y_q == '0))
    else $error("walk did not start at the origin");

  // The walk never leaves the target rectangle.
  a_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (x_q <= last_row_q) && (y_q <= last_col_q))
    else $error("cell index beyond target");

  // The last row never writes column sums.
  a_no_last_row_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (x_q != last_row_q))
    else $error("column sum written in the target row");

  // A new result is loaded only from the finish step.
  a_load_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == ST_FINISH))
    else $error("result appeared outside the finish step");
`endif

endmodule

// File: verif/tb_top.sv
module tb_top;
  import rmpc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int GridSize = GridSizeDef;

  // One target cell as it goes into the block.
  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
  } target_t;

  // One path count as it comes out of the block.
  typedef struct packed {
    logic [CountW-1:0] count;
    logic              sat;
  } path_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [InDataW-1:0] s_tdata = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [CountW-1:0]  m_tdata;
  logic [0:0]         m_tuser;

  target_t      target_q[$];
  path_result_t path_q[$];
  target_t      next_target;
  path_result_t seen_path;
  path_result_t want_path;

  int unsigned send_idle_pct = 35;
  int unsigned recv_idle_pct = 85;
  int unsigned errors = 0;
  longint unsigned cycle_count = 0;
  longint unsigned cycle_limit = 20000;

  rook_move_path_count #(
    .GRID_SIZE(GridSize)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser)
  );

  // Free-running 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Saturating 64-bit add; the top bit flags an overflow.
  function automatic logic [CountW:0] sat_sum(input logic [CountW-1:0] a,
                                              input logic [CountW-1:0] b);
    logic [CountW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[CountW]) s = {1'b1, CountMax};
    return s;
  endfunction

  // Walks the table row by row with running row and column sums, exactly as the
  // block does, so that saturation shows up only where the true count overflows.
  function automatic path_result_t rook_path_count(input logic [RowW-1:0] row_in,
                                                   input logic [ColW-1:0] col_in);
    logic [CountW-1:0] col_acc[GridSize];
    logic [CountW-1:0] run;
    logic [CountW-1:0] cell_val;
    logic [CountW:0]   sum;
    logic              ovf;
    int                last_r;
    int                last_c;
    path_result_t      res;
    last_r = (int'(row_in) >= GridSize) ? GridSize - 1 : int'(row_in);
    last_c = (int'(col_in) >= GridSize) ? GridSize - 1 : int'(col_in);
    for (int i = 0; i < GridSize; i++) col_acc[i] = '0;
    cell_val = '0;
    ovf      = 1'b0;
    for (int x = 0; x <= last_r; x++) begin
      run = '0;
      for (int y = 0; y <= last_c; y++) begin
        if (x == 0 && y == 0) begin
          cell_val = CountW'(1);
        end else begin
          sum      = sat_sum(run, col_acc[y]);
          ovf      = ovf | sum[CountW];
          cell_val = sum[CountW-1:0];
        end
        // The row sum past the target column feeds nothing.
        if (y < last_c) begin
          sum = sat_sum(run, cell_val);
          ovf = ovf | sum[CountW];
          run = sum[CountW-1:0];
        end
        // The column sums in the target row feed nothing.
        if (x < last_r) begin
          sum        = sat_sum(col_acc[y], cell_val);
          ovf        = ovf | sum[CountW];
          col_acc[y] = sum[CountW-1:0];
        end
      end
    end
    res.count = cell_val;
    res.sat   = ovf;
    return res;
  endfunction

  // Queues one target and widens the run limit by a generous bound on its cost.
  task automatic add_target(input int unsigned row, input int unsigned col);
    target_t t;
    t.row = row[RowW-1:0];
    t.col = col[ColW-1:0];
    target_q.push_back(t);
    cycle_limit += 4 * (4 * (longint'(t.row) + 1) * (longint'(t.col) + 1) + 2 + 400);
  endtask

  // Random targets: mostly small grids, some medium, a few up to the full edge.
  task automatic add_random_targets(input int unsigned n);
    int unsigned pick;
    int unsigned top;
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 80) top = 7;
      else if (pick < 95) top = 31;
      else top = GridSize - 1;
      add_target($urandom_range(top), $urandom_range(top));
    end
  endtask

  // Driver: presents queued targets, records the expected count on each accepted item.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        path_q.push_back(rook_path_count(s_tdata[RowW-1:0], s_tdata[RowW+ColW-1:RowW]));
      end
      if (!s_tvalid || s_tready) begin
        if (target_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_target = target_q.pop_front();
          s_tvalid    <= 1'b1;
          s_tdata     <= {{(InDataW-RowW-ColW){1'b0}}, next_target.col, next_target.row};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest expected count.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        seen_path.count = m_tdata;
        seen_path.sat   = m_tuser[0];
        if (path_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected item: expected none, actual count %h sat %b",
                   $time, seen_path.count, seen_path.sat);
        end else begin
          want_path = path_q.pop_front();
          if (seen_path.count !== want_path.count) begin
            errors++;
            $display("%0t: path_count mismatch: expected %h, actual %h",
                     $time, want_path.count, seen_path.count);
          end
          if (seen_path.sat !== want_path.sat) begin
            errors++;
            $display("%0t: saturated mismatch: expected %b, actual %b",
                     $time, want_path.sat, seen_path.sat);
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > cycle_limit) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Reset, then three phases with different idle rates, then drain and report.
  initial begin
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed corners: origin, edges, full grid, alternating bit patterns and
    // the diagonal around where the count first overflows.
    add_target(0, 0);
    add_target(0, 1);
    add_target(1, 0);
    add_target(1, 1);
    add_target(2, 2);
    add_target(3, 5);
    add_target(0, 63);
    add_target(63, 0);
    add_target(1, 63);
    add_target(63, 1);
    add_target(42, 21);
    add_target(21, 42);
    add_target(19, 19);
    add_target(20, 20);
    add_target(21, 21);
    add_target(22, 22);
    add_target(5, 40);
    add_target(40, 5);
    add_target(62, 62);
    add_target(63, 63);
    add_target(0, 0);
    add_random_targets(40);
    while (target_q.size() > 0) @(negedge clk_i);

    send_idle_pct = 85;
    recv_idle_pct = 35;
    add_random_targets(40);
    while (target_q.size() > 0) @(negedge clk_i);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random_targets(39);

    while (target_q.size() > 0 || s_tvalid || path_q.size() > 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
